// ===== hdl/lpm_pkg.sv =====
// Shared constants, types and helper functions for the literal pattern matcher.
`timescale 1ns / 1ps
package lpm_pkg;

	localparam int MAX_PATTERN   = 16;
	localparam int POSITION_BITS = 24;
	localparam int PAGE_BITS     = 16;
	localparam int LINE_BITS     = 24;
	localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
	localparam int PAT_BYTES     = 16;
	localparam int PAT_IDX_W     = $clog2(PAT_BYTES);
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int OUT_TDATA_W   = ((PAGE_BITS + LINE_BITS + POSITION_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W     = OUT_TDATA_W - (PAGE_BITS + LINE_BITS + POSITION_BITS);

	localparam logic [7:0]           NEWLINE_CHAR = 8'h0A;
	localparam logic [LINE_BITS-1:0] LINE_LIMIT   = {LINE_BITS{1'b1}};
	localparam logic [LEN_W-1:0]     NO_RECENT    = LEN_W'(MAX_PATTERN);
	localparam logic [15:0]          COUNT_LIMIT  = 16'hFFFF;
	localparam logic [15:0]          MAX_MATCHES_RESET = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW,
		REG_PAT_HIGH,
		REG_PAT_LEN,
		REG_CASE_FOLD,
		REG_MAX_MATCHES
	} cfg_reg_t;

	// Per-cell compare setup
	typedef struct packed {
		logic [7:0] expect_byte;
		logic       active;
		logic       tail;
	} lpm_cell_cfg_t;

	typedef struct packed {
		logic                     limit_reached;
		logic [POSITION_BITS-1:0] position;
		logic [LINE_BITS-1:0]     line;
		logic [PAGE_BITS-1:0]     page;
	} lpm_result_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && (b inside {[8'h41:8'h5A]})) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

	function automatic logic [7:0] pattern_byte(input logic [8*PAT_BYTES-1:0] pat,
		input logic [LEN_W-1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (32'(idx) < PAT_BYTES) begin
			r = pat[8*32'(idx[PAT_IDX_W-1:0]) +: 8];
		end
		return r;
	endfunction

endpackage

// ===== hdl/literal_pattern_matcher.sv =====
// Top level: config registers, cell chain, page/line/match tracking and output queue.
// A match is written into the output queue when the byte that ends it is taken, and leaves on m_axis from there.
// Throughput: one text byte per cycle, set by the cell chain that shifts on every transaction.
// The input pauses in the cycle after each config write while cells load their compare bytes,
// and whenever two results wait in the output queue.
// Reset (arst_n low): window cleared, line numbers one, page/position/count zero, limit 100.
`timescale 1ns / 1ps
module literal_pattern_matcher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // text_byte
	input  logic                             s_axis_tlast,  // last_of_page
	input  logic                             s_axis_tuser,  // new_search
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [lpm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // match_page, match_line, match_position
	output logic                             m_axis_tuser   // limit_reached
);
	import lpm_pkg::*;

	// configuration
	logic [63:0]      pat_low_q;
	logic [63:0]      pat_high_q;
	logic [LEN_W-1:0] pat_len_q;
	logic             case_fold_q;
	logic [15:0]      max_matches_q;
	logic             cfg_wr_q;
	logic             cfg_acc;

	// tracking state
	logic [PAGE_BITS-1:0]     page_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [LINE_BITS-1:0]     line_q;
	logic [15:0]              count_q;
	logic [LEN_W-1:0]         since_q;
	logic                     stopped_q;

	logic acc;
	logic buf_full;

	logic [PAGE_BITS-1:0]     page_e;
	logic [POSITION_BITS-1:0] pos_e;
	logic [LINE_BITS-1:0]     line_e;
	logic [15:0]              count_e;
	logic [LEN_W-1:0]         since_e;
	logic                     stopped_e;
	logic [LEN_W-1:0]         since_inc;
	logic [LEN_W-1:0]         len_e;
	logic [15:0]              count_inc;
	logic                     match;
	logic                     at_limit;
	logic                     all_hit;
	logic [LINE_BITS-1:0]     line_sel;
	logic [7:0]               folded_in;

	lpm_cell_cfg_t        cell_cfg [MAX_PATTERN];
	logic [7:0]           cell_byte_in [MAX_PATTERN];
	logic [7:0]           cell_byte_out [MAX_PATTERN];
	logic [LINE_BITS-1:0] cell_line_in [MAX_PATTERN];
	logic [LINE_BITS-1:0] cell_line_out [MAX_PATTERN];
	logic [LINE_BITS-1:0] cell_tap [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_hit;

	lpm_result_t result;
	lpm_result_t out_res;

	assign cfg_ready     = 1'b1;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign s_axis_tready = !buf_full && !cfg_wr_q;
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q     <= '0;
			pat_high_q    <= '0;
			pat_len_q     <= '0;
			case_fold_q   <= 1'b0;
			max_matches_q <= MAX_MATCHES_RESET;
			cfg_wr_q      <= 1'b0;
		end else begin
			cfg_wr_q <= cfg_acc;
			if (cfg_acc) begin
				case (cfg_reg_t'(cfg_index))
					REG_PAT_LOW:     pat_low_q     <= cfg_data;
					REG_PAT_HIGH:    pat_high_q    <= cfg_data;
					REG_PAT_LEN:     pat_len_q     <= cfg_data[LEN_W-1:0];
					REG_CASE_FOLD:   case_fold_q   <= cfg_data[0];
					REG_MAX_MATCHES: max_matches_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	assign len_e = (32'(pat_len_q) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : pat_len_q;

	// compare setup per cell: cell i checks pattern byte len-1-i
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			cell_cfg[i].active      = (LEN_W'(i) < len_e);
			cell_cfg[i].tail        = (len_e == LEN_W'(i + 1));
			cell_cfg[i].expect_byte = fold_byte(pattern_byte({pat_high_q, pat_low_q},
				len_e - LEN_W'(1) - LEN_W'(i)), case_fold_q);
		end
	end

	// state as seen by this byte, after an optional new search
	always_comb begin
		if (s_axis_tuser) begin
			page_e    = '0;
			pos_e     = '0;
			line_e    = LINE_BITS'(1);
			count_e   = '0;
			since_e   = NO_RECENT;
			stopped_e = 1'b0;
		end else begin
			page_e    = page_q;
			pos_e     = pos_q;
			line_e    = line_q;
			count_e   = count_q;
			since_e   = since_q;
			stopped_e = stopped_q;
		end
	end

	assign folded_in = fold_byte(s_axis_tdata, case_fold_q);

	genvar g;
	generate
		for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign cell_byte_in[g] = folded_in;
				assign cell_line_in[g] = line_e;
			end else begin : g_link
				assign cell_byte_in[g] = cell_byte_out[g-1];
				assign cell_line_in[g] = cell_line_out[g-1];
			end
			lpm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (acc),
				.cfg_in   (cell_cfg[g]),
				.byte_in  (cell_byte_in[g]),
				.line_in  (cell_line_in[g]),
				.byte_out (cell_byte_out[g]),
				.line_out (cell_line_out[g]),
				.hit      (cell_hit[g]),
				.line_tap (cell_tap[g])
			);
		end
	endgenerate

	always_comb begin
		line_sel = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			line_sel = line_sel | cell_tap[i];
		end
	end

	assign all_hit   = &cell_hit;
	assign since_inc = (since_e < NO_RECENT) ? since_e + LEN_W'(1) : since_e;
	assign match     = (len_e != '0) && !stopped_e && all_hit && (since_inc >= len_e) &&
		(({1'b0, pos_e} + (POSITION_BITS+1)'(1)) >= (POSITION_BITS+1)'(len_e));
	assign count_inc = (count_e < COUNT_LIMIT) ? count_e + 16'd1 : count_e;
	assign at_limit  = (count_inc >= max_matches_q);

	assign result.page          = page_e;
	assign result.line          = line_sel;
	assign result.position      = pos_e + POSITION_BITS'(1) - POSITION_BITS'(len_e);
	assign result.limit_reached = at_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q    <= '0;
			pos_q     <= '0;
			line_q    <= LINE_BITS'(1);
			count_q   <= '0;
			since_q   <= NO_RECENT;
			stopped_q <= 1'b0;
		end else if (acc) begin
			count_q   <= match ? count_inc : count_e;
			stopped_q <= stopped_e || (match && at_limit);
			if (s_axis_tlast) begin
				page_q  <= page_e + PAGE_BITS'(1);
				pos_q   <= '0;
				line_q  <= LINE_BITS'(1);
				since_q <= NO_RECENT;
			end else begin
				page_q  <= page_e;
				pos_q   <= (pos_e != {POSITION_BITS{1'b1}}) ? pos_e + POSITION_BITS'(1) : pos_e;
				line_q  <= ((s_axis_tdata == NEWLINE_CHAR) && (line_e < LINE_LIMIT)) ?
					line_e + LINE_BITS'(1) : line_e;
				since_q <= match ? '0 : since_inc;
			end
		end
	end

	lpm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc && match),
		.push_data (result),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (out_res),
		.full      (buf_full)
	);

	generate
		if (OUT_PAD_W > 0) begin : g_pad
			assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.position, out_res.line, out_res.page};
		end else begin : g_nopad
			assign m_axis_tdata = {out_res.position, out_res.line, out_res.page};
		end
	endgenerate
	assign m_axis_tuser = out_res.limit_reached;

endmodule

// ===== hdl/lpm_cell.sv =====
// One window cell: holds a text byte and its line number, compares the byte shifted in.
`timescale 1ns / 1ps
module lpm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  lpm_pkg::lpm_cell_cfg_t        cfg_in,
	input  logic [7:0]                    byte_in,
	input  logic [lpm_pkg::LINE_BITS-1:0] line_in,
	output logic [7:0]                    byte_out,
	output logic [lpm_pkg::LINE_BITS-1:0] line_out,
	output logic                          hit,
	output logic [lpm_pkg::LINE_BITS-1:0] line_tap
);
	import lpm_pkg::*;

	lpm_cell_cfg_t        cfg_q;
	logic [7:0]           byte_q;
	logic [LINE_BITS-1:0] line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			byte_q <= 8'h00;
			line_q <= LINE_BITS'(1);
		end else begin
			cfg_q <= cfg_in;
			if (shift) begin
				byte_q <= byte_in;
				line_q <= line_in;
			end
		end
	end

	assign byte_out = byte_q;
	assign line_out = line_q;
	assign hit      = !cfg_q.active || (byte_in == cfg_q.expect_byte);
	assign line_tap = cfg_q.tail ? line_in : '0;

endmodule

// ===== hdl/lpm_out_buf.sv =====
// Two-entry result queue between the match logic and the output stream.
`timescale 1ns / 1ps
module lpm_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lpm_pkg::lpm_result_t push_data,
	input  logic                 pop_ready,
	output logic                 out_valid,
	output lpm_pkg::lpm_result_t out_data,
	output logic                 full
);
	import lpm_pkg::*;

	lpm_result_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign pop       = out_valid && pop_ready;
	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
